>>> src/i2cm_pkg.sv
package i2cm_pkg;

  localparam int unsigned TICK_WIDTH_DEF = 16;
  localparam int unsigned PHASE_W = 16;
  localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd400;

  localparam int unsigned CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  localparam int unsigned STEP_W = 6;
  localparam logic [STEP_W-1:0] STEP_IDLE     = 6'd0;
  localparam logic [STEP_W-1:0] STEP_FIRST    = 6'd1;
  localparam logic [STEP_W-1:0] STEP_COND_END = 6'd2;   // start/stop: SDA transition phase
  localparam logic [STEP_W-1:0] STEP_COND_FIN = 6'd3;
  localparam logic [STEP_W-1:0] STEP_LAST_BIT = 6'd16;
  localparam logic [STEP_W-1:0] STEP_ACK_LOW  = 6'd17;
  localparam logic [STEP_W-1:0] STEP_ACK_HIGH = 6'd18;
  localparam logic [STEP_W-1:0] STEP_BYTE_FIN = 6'd19;

  // register index of phase_ticks on the config port
  localparam logic REG_PHASE_TICKS = 1'b0;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy;
    logic       done;
    logic       ack_bit;
    logic [7:0] rx_byte;
  } i2cm_res_t;

endpackage

>>> src/i2cm_core.sv
module i2cm_core import i2cm_pkg::*; #(
  parameter int unsigned TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [7:0]         tx_byte_i,
  input  logic               master_nack_i,
  input  logic               sda_in_i,
  input  logic [PHASE_W-1:0] phase_ticks_i,
  output i2cm_res_t          res_o
);

  localparam int unsigned CW = (TICK_WIDTH > PHASE_W) ? TICK_WIDTH : PHASE_W;
  localparam logic [CW-1:0] TICK_CAP = CW'((64'(1) << TICK_WIDTH) - 64'(1));

  logic [STEP_W-1:0]     step_q, step_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  logic [7:0]            shift_q, shift_d;
  logic [CMD_W-1:0]      op_q, op_d;
  logic                  scl_q, scl_d;
  logic                  sda_q, sda_d;
  logic                  ack_q, ack_d;
  logic                  nack_q, nack_d;
  logic [7:0]            rx_q, rx_d;
  logic                  done;

  logic [CW-1:0]     pt_ext;
  logic [CW-1:0]     limit;
  logic              enter;
  logic [STEP_W-1:0] ph;
  logic [STEP_W-1:0] ph_m1;
  logic [2:0]        bit_sel;

  always_comb begin
    pt_ext = CW'(phase_ticks_i);
    if (pt_ext == '0) begin
      limit = CW'(1);
    end else if (pt_ext > TICK_CAP) begin
      limit = TICK_CAP;
    end else begin
      limit = pt_ext;
    end
  end

  always_comb begin
    step_d  = step_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    op_d    = op_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    nack_d  = nack_q;
    rx_d    = rx_q;
    done    = 1'b0;
    enter   = 1'b0;
    ph      = STEP_IDLE;

    if (step_q == STEP_IDLE) begin
      if (cmd_i >= CMD_START && cmd_i <= CMD_READ) begin
        op_d  = cmd_i;
        enter = 1'b1;
        ph    = STEP_FIRST;
        if (cmd_i == CMD_WRITE) begin
          shift_d = tx_byte_i;
        end
        if (cmd_i == CMD_READ) begin
          shift_d = '0;
          nack_d  = master_nack_i;
        end
      end
    end else if (CW'(tick_q) >= limit) begin
      enter = 1'b1;
      ph    = step_q + STEP_FIRST;
    end else begin
      tick_d = tick_q + TICK_WIDTH'(1);
    end

    ph_m1   = ph - STEP_FIRST;
    bit_sel = 3'd7 - ph_m1[3:1];

    if (enter) begin
      step_d = ph;
      tick_d = TICK_WIDTH'(1);
      case (op_d)
        CMD_START: begin
          if (ph == STEP_FIRST) begin
            scl_d = 1'b1;
            sda_d = 1'b1;
          end else if (ph == STEP_COND_END) begin
            sda_d = 1'b0;
          end else begin
            scl_d = 1'b0;
            done  = 1'b1;
          end
        end
        CMD_STOP: begin
          if (ph == STEP_FIRST) begin
            sda_d = 1'b0;
            scl_d = 1'b1;
          end else if (ph == STEP_COND_END) begin
            sda_d = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (ph <= STEP_LAST_BIT) begin
            if (ph[0]) begin
              scl_d = 1'b0;
              sda_d = shift_d[bit_sel];
            end else begin
              scl_d = 1'b1;
            end
          end else if (ph == STEP_ACK_LOW) begin
            scl_d = 1'b0;
            sda_d = 1'b1;
          end else if (ph == STEP_ACK_HIGH) begin
            scl_d = 1'b1;
            ack_d = sda_in_i;
          end else begin
            scl_d = 1'b0;
            done  = 1'b1;
          end
        end
        CMD_READ: begin
          if (ph <= STEP_LAST_BIT) begin
            if (ph == STEP_FIRST) begin
              sda_d = 1'b1;
            end
            if (ph[0]) begin
              scl_d = 1'b0;
            end else begin
              scl_d   = 1'b1;
              shift_d = {shift_d[6:0], sda_in_i};
            end
          end else if (ph == STEP_ACK_LOW) begin
            scl_d = 1'b0;
            sda_d = nack_d;
          end else if (ph == STEP_ACK_HIGH) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
            rx_d  = shift_d;
            done  = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
      if (done) begin
        step_d = STEP_IDLE;
        op_d   = CMD_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_IDLE;
      tick_q  <= '0;
      shift_q <= '0;
      op_q    <= CMD_NONE;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      ack_q   <= 1'b0;
      nack_q  <= 1'b0;
      rx_q    <= '0;
    end else if (step_i) begin
      step_q  <= step_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      op_q    <= op_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
      nack_q  <= nack_d;
      rx_q    <= rx_d;
    end
  end

  // result reflects the levels after this tick's update
  assign res_o.scl     = scl_d;
  assign res_o.sda_out = sda_d;
  assign res_o.busy    = (step_d != STEP_IDLE);
  assign res_o.done    = done;
  assign res_o.ack_bit = ack_d;
  assign res_o.rx_byte = rx_d;

endmodule

>>> src/i2c_master_byte_engine.sv
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------------
// in       | in_valid_i / in_ready_o    | cmd_i tx_byte_i master_nack_i sda_in_i
// out      | out_valid_o / out_ready_i  | scl_o sda_out_o busy_res_o done_res_o
//          |                            | ack_bit_o rx_byte_o
// config   | psel penable pwrite pready | paddr pwdata prdata
//
// One input word (one bus tick) per cycle while in_ready_o is high; its result
// word is in the output register on the next cycle. The sequencer step is
// combinational. in_ready_o drops only while the output register holds a word
// not taken. Reset: phase_ticks = 400, sequencer idle, SCL and SDA released.
module i2c_master_byte_engine import i2cm_pkg::*; #(
  parameter int unsigned TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [7:0]         tx_byte_i,
  input  logic               master_nack_i,
  input  logic               sda_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               scl_o,
  output logic               sda_out_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic               ack_bit_o,
  output logic [7:0]         rx_byte_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [PHASE_W-1:0] phase_q;
  logic               out_valid_q;
  i2cm_res_t          res;
  i2cm_res_t          res_q;
  logic               in_acc;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PHASE_TICKS) ? {16'b0, phase_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_TICKS_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PHASE_TICKS) begin
      phase_q <= pwdata[PHASE_W-1:0];
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  i2cm_core #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_acc),
    .cmd_i         (cmd_i),
    .tx_byte_i     (tx_byte_i),
    .master_nack_i (master_nack_i),
    .sda_in_i      (sda_in_i),
    .phase_ticks_i (phase_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_o       = res_q.scl;
  assign sda_out_o   = res_q.sda_out;
  assign busy_res_o  = res_q.busy;
  assign done_res_o  = res_q.done;
  assign ack_bit_o   = res_q.ack_bit;
  assign rx_byte_o   = res_q.rx_byte;

`ifndef NO_ASSERTIONS
  // a completing tick never reports busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(busy_res_o && done_res_o))
    else $error("done and busy both set");

  // every accepted word shows up in the output register next cycle
  a_acc_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted word lost");

  // output word held while downstream stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> !in_ready_o || out_ready_i || !in_valid_i || out_valid_o)
    else $error("output register dropped a word");
`endif

endmodule
